// ===== rtl/core/scv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scv_pkg
// shared types, constants and the crc-32 byte step of the container validator
// ----------------------------------------------------------------------------
package scv_pkg;

    localparam int unsigned HEADER_BYTES = 28;
    localparam int unsigned COUNT_W      = 33;
    localparam int unsigned ADDR_W       = 4;
    localparam int unsigned DATA_W       = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] MAGIC_0 = 8'h41;
    localparam logic [7:0] MAGIC_1 = 8'h32;
    localparam logic [7:0] MAGIC_2 = 8'h44;
    localparam logic [7:0] MAGIC_3 = 8'h53;

    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_MIN_SCHEMA  = 2'd1;
    localparam logic [1:0] REG_MAX_SCHEMA  = 2'd2;
    localparam logic [1:0] REG_EXP_VERSION = 2'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FORMAT      = 3'd1,
        ST_CHECKSUM    = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_LIMIT       = 3'd4,
        ST_INVALID_ARG = 3'd5
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scv_if
// valid/ready channels of the container validator: byte beats in, result out
// ----------------------------------------------------------------------------
interface scv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scv_out_if;
    logic             valid;
    logic             ready;
    scv_pkg::t_status status;
    logic [31:0]      schema_out;
    logic [31:0]      payload_length;

    modport source (output valid, output status, output schema_out,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input schema_out,
                    input payload_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/save_container_validator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// save_container_validator
// checks a 28-byte header plus payload container streamed one byte per beat
// ----------------------------------------------------------------------------
// i_byte carries one container byte per beat, last_byte marks the final one.
// o_result gives one beat per container: status, schema and payload length
// (the last two are zero unless status is ok).
// throughput: one byte per cycle while i_byte.ready is high; each byte's
// crc step and field capture is done in the cycle it is accepted, straight
// into the stream registers. the result is valid in the cycle after the
// last byte is accepted. the result sits in an output register; while it
// waits, non-last bytes and the last byte are still taken as long as
// o_result.ready is high or the register is empty, so a stalled receiver
// holds the input only while a finished result is unread.
// the apb port holds four limit registers; write them only between containers.
// reset (synchronous, active low) restores the register defaults and clears
// the stream state; the block is ready the cycle after reset is released.
// ----------------------------------------------------------------------------
module save_container_validator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    scv_in_if.sink                       i_byte,
    scv_out_if.source                    o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [scv_pkg::ADDR_W-1:0]   paddr,
    input  wire  [scv_pkg::DATA_W-1:0]   pwdata,
    output logic [scv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import scv_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] IDX_HCRC  = COUNT_W'(24);
    localparam logic [COUNT_W-1:0] IDX_HDR   = COUNT_W'(HEADER_BYTES);
    localparam logic [COUNT_W-1:0] IDX_LASTH = COUNT_W'(HEADER_BYTES - 1);

    // config registers
    logic [31:0] r_max_payload, r_min_schema, r_max_schema;
    logic [15:0] r_exp_version;
    logic        cfg_wr;

    // stream state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_crc, n_crc;
    logic [31:0]        r_hcrc, n_hcrc;
    logic [15:0]        r_version, n_version;
    logic [15:0]        r_flags, n_flags;
    logic [31:0]        r_schema, n_schema;
    logic [63:0]        r_length, n_length;
    logic [31:0]        r_pcrc, n_pcrc;
    t_status            r_err, n_err;
    logic               r_magic_ok, n_magic_ok;

    // result register
    logic        r_out_valid, n_out_valid;
    t_status     r_out_status, n_out_status;
    logic [31:0] r_out_schema, n_out_schema;
    logic [31:0] r_out_length, n_out_length;

    logic        acc;
    logic [7:0]  b;
    logic [4:0]  pos;
    logic [7:0]  magic_exp;
    logic [64:0] total_exp;
    t_status     st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_MAX_PAYLOAD: prdata = r_max_payload;
            REG_MIN_SCHEMA:  prdata = r_min_schema;
            REG_MAX_SCHEMA:  prdata = r_max_schema;
            REG_EXP_VERSION: prdata = {16'd0, r_exp_version};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= 32'hFFFF_FFFF;
            r_min_schema  <= 32'd0;
            r_max_schema  <= 32'hFFFF_FFFF;
            r_exp_version <= 16'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_PAYLOAD: r_max_payload <= pwdata;
                REG_MIN_SCHEMA:  r_min_schema  <= pwdata;
                REG_MAX_SCHEMA:  r_max_schema  <= pwdata;
                REG_EXP_VERSION: r_exp_version <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign i_byte.ready       = !r_out_valid || o_result.ready;
    assign acc                = i_byte.valid && i_byte.ready;
    assign b                  = i_byte.data_byte;
    assign pos                = r_count[4:0];
    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_status;
    assign o_result.schema_out     = r_out_schema;
    assign o_result.payload_length = r_out_length;

    always_comb begin
        case (pos[1:0])
            2'd0:    magic_exp = MAGIC_0;
            2'd1:    magic_exp = MAGIC_1;
            2'd2:    magic_exp = MAGIC_2;
            default: magic_exp = MAGIC_3;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_crc        = r_crc;
        n_hcrc       = r_hcrc;
        n_version    = r_version;
        n_flags      = r_flags;
        n_schema     = r_schema;
        n_length     = r_length;
        n_pcrc       = r_pcrc;
        n_err        = r_err;
        n_magic_ok   = r_magic_ok;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_status = r_out_status;
        n_out_schema = r_out_schema;
        n_out_length = r_out_length;
        total_exp    = '0;
        st           = ST_OK;

        if (acc) begin
            // field capture, header bytes only
            if (r_count < IDX_HDR) begin
                if (pos < 5'd4) begin
                    if (b != magic_exp) n_magic_ok = 1'b0;
                end else if (pos < 5'd6) begin
                    n_version[8*(pos[0])+:8] = b;
                end else if (pos < 5'd8) begin
                    n_flags[8*(pos[0])+:8] = b;
                end else if (pos < 5'd12) begin
                    n_schema[8*(pos[1:0])+:8] = b;
                end else if (pos < 5'd20) begin
                    n_length[8*(3'(pos - 5'd12))+:8] = b;
                end else if (pos < 5'd24) begin
                    n_pcrc[8*(pos[1:0])+:8] = b;
                end else begin
                    n_hcrc[8*(pos[1:0])+:8] = b;
                end
            end

            if (r_count < IDX_HCRC || r_count >= IDX_HDR) begin
                n_crc = crc_byte(r_crc, b);
            end

            // header checks, first failure wins
            if (r_count == IDX_LASTH) begin
                if (r_err == ST_OK) begin
                    if (!r_magic_ok) begin
                        n_err = ST_FORMAT;
                    end else if (~r_crc != n_hcrc) begin
                        n_err = ST_CHECKSUM;
                    end else if (r_version != r_exp_version) begin
                        n_err = ST_UNSUPPORTED;
                    end else if (r_flags != 16'd0) begin
                        n_err = ST_FORMAT;
                    end else if (r_schema < r_min_schema || r_schema > r_max_schema) begin
                        n_err = ST_UNSUPPORTED;
                    end else if (r_length > {32'd0, r_max_payload}) begin
                        n_err = ST_LIMIT;
                    end
                end
                n_crc = CRC_INIT;
            end

            if (r_count != COUNT_MAX) n_count = r_count + COUNT_W'(1);

            if (i_byte.last_byte) begin
                total_exp = {1'b0, n_length} + 65'(HEADER_BYTES);
                if (r_min_schema > r_max_schema) begin
                    st = ST_INVALID_ARG;
                end else if (n_count < IDX_HDR) begin
                    st = ST_FORMAT;
                end else if (n_err != ST_OK) begin
                    st = n_err;
                end else if ({32'd0, n_count} != total_exp) begin
                    st = ST_FORMAT;
                end else if (~n_crc != n_pcrc) begin
                    st = ST_CHECKSUM;
                end
                n_out_valid  = 1'b1;
                n_out_status = st;
                n_out_schema = (st == ST_OK) ? n_schema : 32'd0;
                n_out_length = (st == ST_OK) ? n_length[31:0] : 32'd0;

                // back to reset for the next container
                n_count    = '0;
                n_crc      = CRC_INIT;
                n_hcrc     = '0;
                n_version  = '0;
                n_flags    = '0;
                n_schema   = '0;
                n_length   = '0;
                n_pcrc     = '0;
                n_err      = ST_OK;
                n_magic_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_hcrc      <= '0;
            r_version   <= '0;
            r_flags     <= '0;
            r_schema    <= '0;
            r_length    <= '0;
            r_pcrc      <= '0;
            r_err       <= ST_OK;
            r_magic_ok  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_hcrc      <= n_hcrc;
            r_version   <= n_version;
            r_flags     <= n_flags;
            r_schema    <= n_schema;
            r_length    <= n_length;
            r_pcrc      <= n_pcrc;
            r_err       <= n_err;
            r_magic_ok  <= n_magic_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_schema <= n_out_schema;
        r_out_length <= n_out_length;
    end

    // a last beat always produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte.last_byte) |=> o_result.valid)
        else $error("no result after last byte");

    // stream state restarts after the last beat
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte.last_byte) |=> (r_count == '0 && r_err == ST_OK && r_magic_ok))
        else $error("stream state not cleared after last byte");

    // schema and length only reported with an ok status
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_OK)
            |-> (o_result.schema_out == 32'd0 && o_result.payload_length == 32'd0))
        else $error("nonzero fields with error status");

    // header error latched only once the header is complete
    a_err_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> (r_count >= IDX_HDR))
        else $error("error latched inside header");

endmodule
`default_nettype wire
